FILE: src/base64_stream_decoder_macros.svh
// assertion macros for the base64 stream decoder
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define B64SD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b64sd assertion failed");

// next-cycle implication, checked out of reset
`define B64SD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b64sd assertion failed");

`endif

FILE: src/b64sd_pkg.sv
// shared types, constants and the character map of the base64 stream decoder
// no dependencies
package b64sd_pkg;

    localparam int unsigned SYMBOL_W = 8;
    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned BYTE_W   = 8;

    typedef logic [SYMBOL_W-1:0] t_symbol;
    typedef logic [SEXTET_W-1:0] t_sextet;
    typedef logic [BYTE_W-1:0]   t_byte;

    // place of a character within its group of four
    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_THIRD  = 2'd2,
        POS_FOURTH = 2'd3
    } t_group_pos;

    localparam t_symbol CH_PAD_EQ  = 8'h3D;  // '='
    localparam t_symbol CH_PAD_DOT = 8'h2E;  // '.'
    localparam t_symbol CH_UPPER_A = 8'h41;
    localparam t_symbol CH_UPPER_Z = 8'h5A;
    localparam t_symbol CH_LOWER_A = 8'h61;
    localparam t_symbol CH_LOWER_Z = 8'h7A;
    localparam t_symbol CH_DIGIT_0 = 8'h30;
    localparam t_symbol CH_DIGIT_9 = 8'h39;
    localparam t_symbol CH_PLUS    = 8'h2B;
    localparam t_symbol CH_MINUS   = 8'h2D;
    localparam t_symbol CH_SLASH   = 8'h2F;
    localparam t_symbol CH_UNDER   = 8'h5F;

    localparam t_symbol LOWER_BASE = 8'd26;
    localparam t_symbol DIGIT_BASE = 8'd52;
    localparam t_sextet SEXTET_62  = 6'd62;
    localparam t_sextet SEXTET_63  = 6'd63;

    // map one character to its sextet, anything outside the alphabet gives zero
    function automatic t_sextet sextet_of(input t_symbol c);
        t_symbol v;
        v = '0;
        case (c) inside
            [CH_UPPER_A:CH_UPPER_Z]: v = c - CH_UPPER_A;
            [CH_LOWER_A:CH_LOWER_Z]: v = c - CH_LOWER_A + LOWER_BASE;
            [CH_DIGIT_0:CH_DIGIT_9]: v = c - CH_DIGIT_0 + DIGIT_BASE;
            CH_PLUS, CH_MINUS:       v = {2'b00, SEXTET_62};
            CH_SLASH, CH_UNDER:      v = {2'b00, SEXTET_63};
            default:                 v = '0;
        endcase
        return v[SEXTET_W-1:0];
    endfunction

    function automatic logic is_pad(input t_symbol c);
        return (c == CH_PAD_EQ) || (c == CH_PAD_DOT);
    endfunction

endpackage

FILE: src/b64sd_if.sv
// valid/ready channel interfaces for characters in and bytes out
// depends on b64sd_pkg
interface b64sd_sym_if
    import b64sd_pkg::*;
();
    logic    valid;
    logic    ready;
    t_symbol symbol;
    logic    end_of_block;

    modport source (output valid, output symbol, output end_of_block, input ready);
    modport sink (input valid, input symbol, input end_of_block, output ready);
endinterface

interface b64sd_byte_if
    import b64sd_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

FILE: src/base64_stream_decoder.sv
// base64 stream decoder, one character per word in, one byte per word out
// depends on b64sd_pkg, b64sd_if and b64sd_group
//
// i_sym carries one character (symbol) and an end_of_block flag per word;
// o_byte carries one decoded data_byte per word. Both are valid/ready and a
// word moves on a rising edge with valid and ready high.
// The first character of a group of four gives no byte, each later one gives
// one byte, and padding ('=' or '.') in the third or fourth place silences
// the rest of its group. end_of_block puts the next character back at the
// first place of a group, so unpadded tails decode in full.
// A character passes the input register, then the character map and byte
// assembly into the output register. Throughput is one character per cycle,
// set by the single group-state update, while the receiver does not stall.
// A stalled receiver holds the output register; the input register still
// takes a character if the one it holds gives no byte, otherwise
// i_sym.ready drops until the output frees up. Reset clears the group state
// and both valid flags; no bytes are pending afterward.
module base64_stream_decoder
    import b64sd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    b64sd_sym_if.sink     i_sym,
    b64sd_byte_if.source  o_byte
);

    logic    r_in_valid;
    t_symbol r_in_symbol;
    logic    r_in_eob;
    logic    r_out_valid;
    t_byte   r_out_byte;
    logic    emit;
    t_byte   dec_byte;
    logic    out_free;
    logic    advance;

    // hand the registered character on when its byte, if any, has room
    assign out_free    = !r_out_valid || o_byte.ready;
    assign advance     = r_in_valid && (!emit || out_free);
    assign i_sym.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sym.ready) begin
            r_in_valid <= i_sym.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sym.ready && i_sym.valid) begin
            r_in_symbol <= i_sym.symbol;
            r_in_eob    <= i_sym.end_of_block;
        end
    end

    b64sd_group u_group (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_symbol       (r_in_symbol),
        .i_end_of_block (r_in_eob),
        .o_emit         (emit),
        .o_data_byte    (dec_byte)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_byte.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_byte <= dec_byte;
        end
    end

    assign o_byte.valid     = r_out_valid;
    assign o_byte.data_byte = r_out_byte;

endmodule

FILE: src/b64sd_group.sv
// group tracking state and byte assembly for one registered character
// depends on b64sd_pkg and base64_stream_decoder_macros.svh
`include "base64_stream_decoder_macros.svh"

module b64sd_group
    import b64sd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_symbol i_symbol,
    input  logic    i_end_of_block,
    output logic    o_emit,
    output t_byte   o_data_byte
);

    t_group_pos r_pos, n_pos;
    t_sextet    r_prev;
    logic       r_pad, n_pad;
    t_sextet    cur;
    logic       pad_char;

    assign cur      = sextet_of(i_symbol);
    assign pad_char = is_pad(i_symbol);

    // byte assembly and next group state
    always_comb begin
        o_emit      = 1'b0;
        o_data_byte = '0;
        n_pad       = r_pad;
        case (r_pos)
            POS_FIRST: begin
                n_pad = 1'b0;
            end
            POS_SECOND: begin
                o_emit      = 1'b1;
                o_data_byte = {r_prev, cur[5:4]};
            end
            POS_THIRD: begin
                if (r_pad || pad_char) begin
                    n_pad = 1'b1;
                end else begin
                    o_emit      = 1'b1;
                    o_data_byte = {r_prev[3:0], cur[5:2]};
                end
            end
            POS_FOURTH: begin
                if (r_pad || pad_char) begin
                    n_pad = 1'b1;
                end else begin
                    o_emit      = 1'b1;
                    o_data_byte = {r_prev[1:0], cur};
                end
            end
            default: begin
                n_pad = r_pad;
            end
        endcase
        n_pos = t_group_pos'(r_pos + 2'd1);
        if (i_end_of_block) begin
            n_pos = POS_FIRST;
            n_pad = 1'b0;
        end
    end

    // state advances once per character taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_FIRST;
            r_pad  <= 1'b0;
            r_prev <= '0;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_pad  <= n_pad;
            r_prev <= cur;
        end
    end

    `B64SD_ASSERT_NEXT(a_eob_realigns, i_step && i_end_of_block, r_pos == POS_FIRST && !r_pad)
    `B64SD_ASSERT_NOW(a_first_silent, i_step && r_pos == POS_FIRST, !o_emit)
    `B64SD_ASSERT_NOW(a_pad_silent, r_pad && (r_pos == POS_THIRD || r_pos == POS_FOURTH), !o_emit)

endmodule
